// ===== sv/clipped_scaled_alpha_blitter_core_defines.svh =====
// Assertion macros used by the blitter controller RTL.
`ifndef CLIPPED_SCALED_ALPHA_BLITTER_CORE_DEFINES_SVH
`define CLIPPED_SCALED_ALPHA_BLITTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CSAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("csab assertion failed");
`define CSAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csab implication failed");
`else
`define CSAB_ASSERT(lbl, prop)
`define CSAB_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== sv/csab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package csab_pkg;

  localparam int CoordBitsDef = 12;
  localparam int PixW = 32;
  localparam int RgbW = 24;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_SRC_PIX = 2'd1,
    OP_DST_PIX = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_SRC_RD = 2'd0,
    KIND_DST_RD = 2'd1,
    KIND_DST_WR = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_IMG_SIZE = 3'd0,
    REG_SRC_ORG  = 3'd1,
    REG_SRC_EXT  = 3'd2,
    REG_DST_ORG  = 3'd3,
    REG_DST_EXT  = 3'd4,
    REG_FB_SIZE  = 3'd5,
    REG_BLEND    = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SRC  = 2'd1,
    PH_DST  = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IN,
    ST_CLIP,
    ST_SEEK_FIRST,
    ST_SEEK_NEXT,
    ST_DIVX,
    ST_DIVX_WAIT,
    ST_DIVY,
    ST_DIVY_WAIT,
    ST_SRC_IDX,
    ST_EMIT_SRC,
    ST_EMIT_FIN,
    ST_EMIT_DRD,
    ST_EMIT_WR,
    ST_BLEND_MUL,
    ST_BLEND_DIV
  } state_e;

  typedef enum logic [1:0] {
    IX_ZERO,
    IX_SRC,
    IX_DST
  } idx_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_RGB,
    WD_BLEND
  } wd_sel_e;

  typedef struct packed {
    logic     hold_src;
    logic     hold_dst;
    logic     clip;
    logic     seek;
    logic     seek_next;
    logic     div_start;
    logic     div_y;
    logic     src_idx;
    logic     blend_mul;
    logic     blend_div;
    logic     push;
    kind_e    kind;
    idx_sel_e idx_sel;
    wd_sel_e  wd_sel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic clip_ok;
    logic found;
    logic div_done;
    logic slot_free;
    logic opaque;
    logic alpha_zero;
    logic alpha_full;
  } status_t;

  function automatic logic [RgbW-1:0] rgb_of(input logic [PixW-1:0] p);
    rgb_of = {p[7:0], p[15:8], p[23:16]};
  endfunction

  // Exact x / 255 for the blend sums, which never exceed 255 * 255.
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] t;
    t = x + 17'd1 + {8'd0, x[16:8]};
    div255 = t[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== sv/csab_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface csab_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] pixel_data;
  modport source(output valid, opcode, pixel_data, input ready);
  modport sink(input valid, opcode, pixel_data, output ready);
endinterface

interface csab_result_if #(
  parameter int IdxW = 2 * csab_pkg::CoordBitsDef
);
  logic            valid;
  logic            ready;
  logic [1:0]      request_kind;
  logic [IdxW-1:0] pixel_index;
  logic [23:0]     write_data;
  logic            last_of_run;
  modport source(output valid, request_kind, pixel_index, write_data, last_of_run,
                 input ready);
  modport sink(input valid, request_kind, pixel_index, write_data, last_of_run,
               output ready);
endinterface
`default_nettype wire

// ===== sv/csab_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module csab_dp #(
  parameter int CoordBits = csab_pkg::CoordBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [2:0]                   cfg_idx_i,
  input  wire  [2*CoordBits+1:0]       cfg_data_i,
  input  wire  [csab_pkg::PixW-1:0]    pix_i,
  input  csab_pkg::cmd_t               cmd_i,
  output csab_pkg::status_t            status_o,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   out_kind_o,
  output logic [2*CoordBits-1:0]       out_index_o,
  output logic [csab_pkg::RgbW-1:0]    out_wdata_o,
  output logic                         out_last_o
);

  localparam int C    = CoordBits;
  localparam int W    = C + 3;
  localparam int IdxW = 2 * C;
  localparam int CntW = $clog2(C);
  localparam logic signed [W-1:0] OneW = W'(1);

  logic [IdxW-1:0] img_size_q, src_ext_q, dst_ext_q, fb_size_q;
  logic [IdxW+1:0] src_org_q, dst_org_q;
  logic            blend_q;

  logic [C-1:0] col_q, row_q, cx_q, cy_q, cw_q, ch_q, qx_q, qy_q;
  logic [csab_pkg::PixW-1:0] held_q;
  logic [csab_pkg::RgbW-1:0] dst_pix_q;
  logic [16:0]               mix_q [3];
  logic [csab_pkg::RgbW-1:0] blended_q;
  logic [IdxW-1:0]           src_idx_q;

  logic [C-1:0]    rem_q, low_q, dv_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q, sel_y_q;

  logic                      out_valid_q, out_last_q;
  logic [1:0]                out_kind_q;
  logic [IdxW-1:0]           out_index_q;
  logic [csab_pkg::RgbW-1:0] out_wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_size_q <= '0;
      src_org_q  <= '0;
      src_ext_q  <= '0;
      dst_org_q  <= '0;
      dst_ext_q  <= '0;
      fb_size_q  <= '0;
      blend_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csab_pkg::REG_IMG_SIZE: img_size_q <= cfg_data_i[IdxW-1:0];
        csab_pkg::REG_SRC_ORG:  src_org_q  <= cfg_data_i;
        csab_pkg::REG_SRC_EXT:  src_ext_q  <= cfg_data_i[IdxW-1:0];
        csab_pkg::REG_DST_ORG:  dst_org_q  <= cfg_data_i;
        csab_pkg::REG_DST_EXT:  dst_ext_q  <= cfg_data_i[IdxW-1:0];
        csab_pkg::REG_FB_SIZE:  fb_size_q  <= cfg_data_i[IdxW-1:0];
        csab_pkg::REG_BLEND:    blend_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] dox, doy, dw, dh, fw, fh;
  logic signed [W-1:0] cx_lo, cx_hi, ry_lo, ry_hi, cand_c, cand_r;
  logic                seek_found;

  assign dox = {{2{dst_org_q[C]}}, dst_org_q[C:0]};
  assign doy = {{2{dst_org_q[2*C+1]}}, dst_org_q[2*C+1:C+1]};
  assign dw  = {3'b000, dst_ext_q[C-1:0]};
  assign dh  = {3'b000, dst_ext_q[2*C-1:C]};
  assign fw  = {3'b000, fb_size_q[C-1:0]};
  assign fh  = {3'b000, fb_size_q[2*C-1:C]};

  always_comb begin
    cx_lo = (dox < 0) ? -dox : '0;
    cx_hi = dw - OneW;
    if (fw - OneW - dox < cx_hi) begin
      cx_hi = fw - OneW - dox;
    end
    ry_lo = (doy < 0) ? -doy : '0;
    ry_hi = dh - OneW;
    if (fh - OneW - doy < ry_hi) begin
      ry_hi = fh - OneW - doy;
    end
    if (cmd_i.seek_next) begin
      cand_c = {3'b000, col_q} + OneW;
      cand_r = {3'b000, row_q};
    end else begin
      cand_c = '0;
      cand_r = '0;
    end
    if (cand_r < ry_lo) begin
      cand_r = ry_lo;
      cand_c = cx_lo;
    end
    if (cand_c < cx_lo) begin
      cand_c = cx_lo;
    end
    if (cand_c > cx_hi) begin
      cand_c = cx_lo;
      cand_r = cand_r + OneW;
    end
    seek_found = !(cx_lo > cx_hi) && !(ry_lo > ry_hi) && !(cand_r > ry_hi);
  end

  logic signed [W-1:0] csx, csy, csw, csh, iw, ih;
  logic                clip_ok;

  always_comb begin
    csx = {{2{src_org_q[C]}}, src_org_q[C:0]};
    csy = {{2{src_org_q[2*C+1]}}, src_org_q[2*C+1:C+1]};
    csw = {3'b000, src_ext_q[C-1:0]};
    csh = {3'b000, src_ext_q[2*C-1:C]};
    iw  = {3'b000, img_size_q[C-1:0]};
    ih  = {3'b000, img_size_q[2*C-1:C]};
    clip_ok = (csw > 0) && (csh > 0) && (dw > 0) && (dh > 0);
    if (csx < 0) begin
      csw = csw + csx;
      csx = '0;
    end
    if (csy < 0) begin
      csh = csh + csy;
      csy = '0;
    end
    if (csx + csw > iw) begin
      csw = iw - csx;
    end
    if (csy + csh > ih) begin
      csh = ih - csy;
    end
    clip_ok = clip_ok && (csw > 0) && (csh > 0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip) begin
      cx_q <= csx[C-1:0];
      cy_q <= csy[C-1:0];
      cw_q <= csw[C-1:0];
      ch_q <= csh[C-1:0];
    end
    if (cmd_i.seek && seek_found) begin
      col_q <= cand_c[C-1:0];
      row_q <= cand_r[C-1:0];
    end
    if (cmd_i.hold_src) begin
      held_q <= pix_i;
    end
    if (cmd_i.hold_dst) begin
      dst_pix_q <= pix_i[csab_pkg::RgbW-1:0];
    end
  end

  // Shared restoring divider: one quotient bit per cycle.
  logic [IdxW-1:0] div_prod;
  logic [C:0]      trial;
  logic            trial_ge;

  assign div_prod = cmd_i.div_y ? IdxW'(row_q) * IdxW'(ch_q) : IdxW'(col_q) * IdxW'(cw_q);
  assign trial    = {rem_q, low_q[C-1]};
  assign trial_ge = trial >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(C - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q   <= div_prod[IdxW-1:C];
      low_q   <= div_prod[C-1:0];
      dv_q    <= cmd_i.div_y ? dst_ext_q[2*C-1:C] : dst_ext_q[C-1:0];
      sel_y_q <= cmd_i.div_y;
    end else if (busy_q) begin
      rem_q <= trial_ge ? C'(trial - {1'b0, dv_q}) : trial[C-1:0];
      low_q <= {low_q[C-2:0], trial_ge};
    end
    if (done_q) begin
      if (sel_y_q) begin
        qy_q <= low_q;
      end else begin
        qx_q <= low_q;
      end
    end
  end

  logic [C:0]      sy_sum;
  logic [IdxW-1:0] src_idx;
  logic signed [W-1:0] ddx, ddy;
  logic [IdxW-1:0]     dst_idx;

  assign sy_sum  = {1'b0, cy_q} + {1'b0, qy_q};
  assign src_idx = IdxW'(sy_sum) * IdxW'(img_size_q[C-1:0]) + IdxW'(cx_q) + IdxW'(qx_q);
  assign ddx     = dox + {3'b000, col_q};
  assign ddy     = doy + {3'b000, row_q};
  assign dst_idx = {{(IdxW-W){ddy[W-1]}}, ddy} * IdxW'(fb_size_q[C-1:0])
                 + {{(IdxW-W){ddx[W-1]}}, ddx};

  logic [7:0] alpha, alpha_n;
  assign alpha   = held_q[31:24];
  assign alpha_n = 8'd255 - alpha;

  always_ff @(posedge clk_i) begin
    if (cmd_i.src_idx) begin
      src_idx_q <= src_idx;
    end
    if (cmd_i.blend_mul) begin
      mix_q[0] <= 17'(held_q[7:0] * alpha) + 17'(dst_pix_q[23:16] * alpha_n);
      mix_q[1] <= 17'(held_q[15:8] * alpha) + 17'(dst_pix_q[15:8] * alpha_n);
      mix_q[2] <= 17'(held_q[23:16] * alpha) + 17'(dst_pix_q[7:0] * alpha_n);
    end
    if (cmd_i.blend_div) begin
      blended_q <= {csab_pkg::div255(mix_q[0]), csab_pkg::div255(mix_q[1]),
                    csab_pkg::div255(mix_q[2])};
    end
  end

  logic slot_free;
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_kind_q <= cmd_i.kind;
      out_last_q <= cmd_i.last;
      case (cmd_i.idx_sel)
        csab_pkg::IX_SRC: out_index_q <= src_idx_q;
        csab_pkg::IX_DST: out_index_q <= dst_idx;
        default:          out_index_q <= '0;
      endcase
      case (cmd_i.wd_sel)
        csab_pkg::WD_RGB:   out_wdata_q <= csab_pkg::rgb_of(held_q);
        csab_pkg::WD_BLEND: out_wdata_q <= blended_q;
        default:            out_wdata_q <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_index_o = out_index_q;
  assign out_wdata_o = out_wdata_q;
  assign out_last_o  = out_last_q;

  assign status_o.clip_ok    = clip_ok;
  assign status_o.found      = seek_found;
  assign status_o.div_done   = done_q;
  assign status_o.slot_free  = slot_free;
  assign status_o.opaque     = !blend_q;
  assign status_o.alpha_zero = pix_i[31:24] == 8'd0;
  assign status_o.alpha_full = pix_i[31:24] == 8'hFF;

endmodule
`default_nettype wire

// ===== sv/csab_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_scaled_alpha_blitter_core_defines.svh"
module csab_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire  [1:0]         opcode_i,
  output logic               in_ready_o,
  input  csab_pkg::status_t  status_i,
  output csab_pkg::cmd_t     cmd_o
);

  csab_pkg::state_e state_q, state_d;
  csab_pkg::phase_e phase_q, phase_d;
  logic             wr_blend_q, wr_blend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= csab_pkg::ST_IN;
      phase_q    <= csab_pkg::PH_IDLE;
      wr_blend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      wr_blend_q <= wr_blend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    wr_blend_d = wr_blend_q;
    case (state_q)
      csab_pkg::ST_IN: begin
        if (in_valid_i) begin
          case (opcode_i)
            csab_pkg::OP_START: begin
              if (phase_q == csab_pkg::PH_IDLE) begin
                state_d = csab_pkg::ST_CLIP;
              end
            end
            csab_pkg::OP_SRC_PIX: begin
              if (phase_q == csab_pkg::PH_SRC) begin
                if (status_i.opaque || status_i.alpha_full) begin
                  state_d    = csab_pkg::ST_EMIT_WR;
                  wr_blend_d = 1'b0;
                end else if (status_i.alpha_zero) begin
                  state_d = csab_pkg::ST_SEEK_NEXT;
                end else begin
                  state_d = csab_pkg::ST_EMIT_DRD;
                end
              end
            end
            csab_pkg::OP_DST_PIX: begin
              if (phase_q == csab_pkg::PH_DST) begin
                state_d = csab_pkg::ST_BLEND_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      csab_pkg::ST_CLIP: begin
        state_d = status_i.clip_ok ? csab_pkg::ST_SEEK_FIRST : csab_pkg::ST_EMIT_FIN;
      end
      csab_pkg::ST_SEEK_FIRST, csab_pkg::ST_SEEK_NEXT: begin
        state_d = status_i.found ? csab_pkg::ST_DIVX : csab_pkg::ST_EMIT_FIN;
      end
      csab_pkg::ST_DIVX: state_d = csab_pkg::ST_DIVX_WAIT;
      csab_pkg::ST_DIVX_WAIT: begin
        if (status_i.div_done) begin
          state_d = csab_pkg::ST_DIVY;
        end
      end
      csab_pkg::ST_DIVY: state_d = csab_pkg::ST_DIVY_WAIT;
      csab_pkg::ST_DIVY_WAIT: begin
        if (status_i.div_done) begin
          state_d = csab_pkg::ST_SRC_IDX;
        end
      end
      csab_pkg::ST_SRC_IDX: state_d = csab_pkg::ST_EMIT_SRC;
      csab_pkg::ST_EMIT_SRC: begin
        if (status_i.slot_free) begin
          state_d = csab_pkg::ST_IN;
          phase_d = csab_pkg::PH_SRC;
        end
      end
      csab_pkg::ST_EMIT_FIN: begin
        if (status_i.slot_free) begin
          state_d = csab_pkg::ST_IN;
          phase_d = csab_pkg::PH_IDLE;
        end
      end
      csab_pkg::ST_EMIT_DRD: begin
        if (status_i.slot_free) begin
          state_d = csab_pkg::ST_IN;
          phase_d = csab_pkg::PH_DST;
        end
      end
      csab_pkg::ST_EMIT_WR: begin
        if (status_i.slot_free) begin
          state_d = csab_pkg::ST_SEEK_NEXT;
        end
      end
      csab_pkg::ST_BLEND_MUL: state_d = csab_pkg::ST_BLEND_DIV;
      csab_pkg::ST_BLEND_DIV: begin
        state_d    = csab_pkg::ST_EMIT_WR;
        wr_blend_d = 1'b1;
      end
      default: state_d = csab_pkg::ST_IN;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = csab_pkg::KIND_DONE;
    cmd_o.idx_sel = csab_pkg::IX_ZERO;
    cmd_o.wd_sel  = csab_pkg::WD_ZERO;
    in_ready_o    = 1'b0;
    case (state_q)
      csab_pkg::ST_IN: begin
        in_ready_o     = 1'b1;
        cmd_o.hold_src = in_valid_i && (opcode_i == csab_pkg::OP_SRC_PIX)
                         && (phase_q == csab_pkg::PH_SRC);
        cmd_o.hold_dst = in_valid_i && (opcode_i == csab_pkg::OP_DST_PIX)
                         && (phase_q == csab_pkg::PH_DST);
      end
      csab_pkg::ST_CLIP:       cmd_o.clip = 1'b1;
      csab_pkg::ST_SEEK_FIRST: cmd_o.seek = 1'b1;
      csab_pkg::ST_SEEK_NEXT: begin
        cmd_o.seek      = 1'b1;
        cmd_o.seek_next = 1'b1;
      end
      csab_pkg::ST_DIVX: cmd_o.div_start = 1'b1;
      csab_pkg::ST_DIVY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_y     = 1'b1;
      end
      csab_pkg::ST_SRC_IDX: cmd_o.src_idx = 1'b1;
      csab_pkg::ST_EMIT_SRC: begin
        cmd_o.push    = status_i.slot_free;
        cmd_o.kind    = csab_pkg::KIND_SRC_RD;
        cmd_o.idx_sel = csab_pkg::IX_SRC;
        cmd_o.last    = 1'b1;
      end
      csab_pkg::ST_EMIT_FIN: begin
        cmd_o.push = status_i.slot_free;
        cmd_o.last = 1'b1;
      end
      csab_pkg::ST_EMIT_DRD: begin
        cmd_o.push    = status_i.slot_free;
        cmd_o.kind    = csab_pkg::KIND_DST_RD;
        cmd_o.idx_sel = csab_pkg::IX_DST;
        cmd_o.last    = 1'b1;
      end
      csab_pkg::ST_EMIT_WR: begin
        cmd_o.push    = status_i.slot_free;
        cmd_o.kind    = csab_pkg::KIND_DST_WR;
        cmd_o.idx_sel = csab_pkg::IX_DST;
        cmd_o.wd_sel  = wr_blend_q ? csab_pkg::WD_BLEND : csab_pkg::WD_RGB;
      end
      csab_pkg::ST_BLEND_MUL: cmd_o.blend_mul = 1'b1;
      csab_pkg::ST_BLEND_DIV: cmd_o.blend_div = 1'b1;
      default: ;
    endcase
  end

  `CSAB_ASSERT_IMP(a_push_has_slot, cmd_o.push, status_i.slot_free)
  `CSAB_ASSERT_IMP(a_no_push_while_ready, in_ready_o, !cmd_o.push)
  `CSAB_ASSERT(a_fin_goes_idle, (state_q == csab_pkg::ST_EMIT_FIN && status_i.slot_free) |=> (phase_q == csab_pkg::PH_IDLE))
  `CSAB_ASSERT(a_div_start_once, cmd_o.div_start |=> !cmd_o.div_start)

endmodule
`default_nettype wire

// ===== sv/clipped_scaled_alpha_blitter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Nearest-neighbor scaled alpha blitter. An item is taken whenever the block waits for
// input; each accepted item answers with zero, one or two request items through a
// one-entry output register. After a start or a returned pixel, the next source read
// waits on the shared one-bit-per-cycle divider, which runs twice per pixel, once for x
// and once for y. A destination read passes from its source pixel item through EMIT_DRD
// and the output register, a blended write from its destination pixel item through
// BLEND_MUL, BLEND_DIV, EMIT_WR and the output register; a result-side stall can hold
// either. The user must change registers only while the block waits; it is not enforced.
module clipped_scaled_alpha_blitter_core #(
  parameter int COORD_BITS = csab_pkg::CoordBitsDef
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire  [2:0]              cfg_idx_i,
  input  wire  [2*COORD_BITS+1:0] cfg_data_i,
  csab_item_if.sink               item_i,
  csab_result_if.source           result_o
);

  csab_pkg::cmd_t    cmd;
  csab_pkg::status_t status;

  csab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .opcode_i   (item_i.opcode),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csab_dp #(
    .CoordBits (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (item_i.pixel_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_kind_o  (result_o.request_kind),
    .out_index_o (result_o.pixel_index),
    .out_wdata_o (result_o.write_data),
    .out_last_o  (result_o.last_of_run)
  );

endmodule
`default_nettype wire

// ===== bench/csab_checker.sv =====
`timescale 1ns / 1ps
module csab_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [25:0]           cfg_data_i,
  csab_item_if                  item_mon,
  csab_result_if                result_mon,
  output int                    fail_count,
  output int                    pending_count,
  output csab_pkg::phase_e      walk_phase
);
  import csab_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] index;
    logic [23:0] data;
    logic        last;
  } request_t;

  request_t    request_q[$];
  logic [25:0] regs [7];
  phase_e      phase_q;
  int          col, row, clip_x, clip_y, clip_w, clip_h;
  logic [31:0] held_pixel;
  int          produced;
  int          fails;

  assign fail_count    = fails;
  assign pending_count = request_q.size();
  assign walk_phase    = phase_q;

  function automatic int low12(logic [25:0] v);
    return int'(v[11:0]);
  endfunction

  function automatic int high12(logic [25:0] v);
    return int'(v[23:12]);
  endfunction

  function automatic int sext13(logic [12:0] v);
    return v[12] ? int'(v) - 8192 : int'(v);
  endfunction

  function automatic int org_x(logic [25:0] v);
    return sext13(v[12:0]);
  endfunction

  function automatic int org_y(logic [25:0] v);
    return sext13(v[25:13]);
  endfunction

  function automatic void span(input int o, input int e, input int f,
                               output int lo, output int hi);
    lo = (o < 0) ? -o : 0;
    hi = e - 1;
    if (f - 1 - o < hi) hi = f - 1 - o;
  endfunction

  function automatic bit find_pixel(int c, int r);
    int xlo, xhi, ylo, yhi;
    span(org_x(regs[REG_DST_ORG]), low12(regs[REG_DST_EXT]), low12(regs[REG_FB_SIZE]),
         xlo, xhi);
    span(org_y(regs[REG_DST_ORG]), high12(regs[REG_DST_EXT]), high12(regs[REG_FB_SIZE]),
         ylo, yhi);
    if (xlo > xhi || ylo > yhi) return 0;
    if (r < ylo) begin
      r = ylo;
      c = xlo;
    end
    if (c < xlo) c = xlo;
    if (c > xhi) begin
      c = xlo;
      r++;
    end
    if (r > yhi) return 0;
    col = c;
    row = r;
    return 1;
  endfunction

  function automatic void emit(kind_e kind, longint index, logic [23:0] data);
    request_t req;
    req.kind  = kind;
    req.index = index[23:0];
    req.data  = data;
    req.last  = 1'b0;
    request_q.push_back(req);
    produced++;
  endfunction

  function automatic longint dst_index();
    longint dx, dy;
    dx = longint'(org_x(regs[REG_DST_ORG]) + col);
    dy = longint'(org_y(regs[REG_DST_ORG]) + row);
    return dy * longint'(low12(regs[REG_FB_SIZE])) + dx;
  endfunction

  function automatic void issue(bit found);
    longint sx, sy;
    if (found) begin
      sx = longint'(clip_x) + longint'(col) * clip_w / low12(regs[REG_DST_EXT]);
      sy = longint'(clip_y) + longint'(row) * clip_h / high12(regs[REG_DST_EXT]);
      emit(KIND_SRC_RD, sy * longint'(low12(regs[REG_IMG_SIZE])) + sx, 24'd0);
      phase_q = PH_SRC;
    end else begin
      emit(KIND_DONE, 0, 24'd0);
      phase_q = PH_IDLE;
    end
  endfunction

  function automatic logic [7:0] mix(int s, int d, int a);
    return 8'((s * a + d * (255 - a)) / 255);
  endfunction

  function automatic void step(logic [1:0] op, logic [31:0] pix);
    int sx, sy, sw, sh, iw, ih, a;
    bit ok;
    logic [7:0] r, g, b;
    produced = 0;
    if (op == OP_START && phase_q == PH_IDLE) begin
      sx = org_x(regs[REG_SRC_ORG]);
      sy = org_y(regs[REG_SRC_ORG]);
      sw = low12(regs[REG_SRC_EXT]);
      sh = high12(regs[REG_SRC_EXT]);
      iw = low12(regs[REG_IMG_SIZE]);
      ih = high12(regs[REG_IMG_SIZE]);
      ok = sw > 0 && sh > 0 && low12(regs[REG_DST_EXT]) > 0 && high12(regs[REG_DST_EXT]) > 0;
      if (ok) begin
        if (sx < 0) begin
          sw += sx;
          sx = 0;
        end
        if (sy < 0) begin
          sh += sy;
          sy = 0;
        end
        if (sx + sw > iw) sw = iw - sx;
        if (sy + sh > ih) sh = ih - sy;
        ok = sw > 0 && sh > 0;
      end
      if (ok) begin
        clip_x = sx;
        clip_y = sy;
        clip_w = sw;
        clip_h = sh;
        issue(find_pixel(0, 0));
      end else begin
        emit(KIND_DONE, 0, 24'd0);
        phase_q = PH_IDLE;
      end
    end else if (op == OP_SRC_PIX && phase_q == PH_SRC) begin
      a = int'(pix[31:24]);
      held_pixel = pix;
      if (regs[REG_BLEND][0] == 1'b0 || a == 255) begin
        emit(KIND_DST_WR, dst_index(), {pix[7:0], pix[15:8], pix[23:16]});
        issue(find_pixel(col + 1, row));
      end else if (a == 0) begin
        issue(find_pixel(col + 1, row));
      end else begin
        emit(KIND_DST_RD, dst_index(), 24'd0);
        phase_q = PH_DST;
      end
    end else if (op == OP_DST_PIX && phase_q == PH_DST) begin
      a = int'(held_pixel[31:24]);
      r = mix(int'(held_pixel[7:0]), int'(pix[23:16]), a);
      g = mix(int'(held_pixel[15:8]), int'(pix[15:8]), a);
      b = mix(int'(held_pixel[23:16]), int'(pix[7:0]), a);
      emit(KIND_DST_WR, dst_index(), {r, g, b});
      issue(find_pixel(col + 1, row));
    end
    if (produced > 0) request_q[request_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    request_t exp_req;
    if (!rst_ni) begin
      request_q.delete();
      for (int i = 0; i < 7; i++) regs[i] = '0;
      regs[REG_BLEND] = 26'd1;
      phase_q = PH_IDLE;
      col = 0;
      row = 0;
      clip_x = 0;
      clip_y = 0;
      clip_w = 0;
      clip_h = 0;
      held_pixel = '0;
      fails = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < 3'd7) regs[cfg_idx_i] = cfg_data_i;
      if (item_mon.valid && item_mon.ready) step(item_mon.opcode, item_mon.pixel_data);
      if (result_mon.valid && result_mon.ready) begin
        if (request_q.size() == 0) begin
          $error("unexpected result item: kind %0d index %0h", result_mon.request_kind,
                 result_mon.pixel_index);
          fails++;
        end else begin
          exp_req = request_q.pop_front();
          if (result_mon.request_kind !== exp_req.kind) begin
            $error("request_kind: expected %0d, got %0d", exp_req.kind,
                   result_mon.request_kind);
            fails++;
          end
          if (result_mon.pixel_index !== exp_req.index) begin
            $error("pixel_index: expected %0h, got %0h", exp_req.index,
                   result_mon.pixel_index);
            fails++;
          end
          if (result_mon.write_data !== exp_req.data) begin
            $error("write_data: expected %0h, got %0h", exp_req.data,
                   result_mon.write_data);
            fails++;
          end
          if (result_mon.last_of_run !== exp_req.last) begin
            $error("last_of_run: expected %0d, got %0d", exp_req.last,
                   result_mon.last_of_run);
            fails++;
          end
        end
      end
    end
  end
endmodule

// ===== bench/clipped_scaled_alpha_blitter_core_tb.sv =====
`timescale 1ns / 1ps
module clipped_scaled_alpha_blitter_core_tb;
  import csab_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [25:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;
  phase_e      walk_phase;
  int          items_sent = 0;
  bit          stuck = 0;

  csab_item_if   item_bus ();
  csab_result_if result_bus ();

  clipped_scaled_alpha_blitter_core DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .item_i    (item_bus),
    .result_o  (result_bus)
  );

  csab_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .item_mon     (item_bus),
    .result_mon   (result_bus),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .walk_phase   (walk_phase)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] pack_size(int w, int h);
    return {12'(h), 12'(w)};
  endfunction

  function automatic logic [25:0] pack_org(int x, int y);
    return {13'(y), 13'(x)};
  endfunction

  function automatic logic [31:0] make_pixel(bit directed, int i);
    int r;
    if (directed) begin
      case (i % 4)
        0: return 32'h00FF_FFFF;
        1: return 32'hFF00_0000;
        2: return 32'h01FF_FFFF;
        default: return 32'hFE00_0000;
      endcase
    end
    r = $urandom_range(0, 3);
    if (r == 0) return {8'h00, 24'($urandom)};
    if (r == 1) return {8'hFF, 24'($urandom)};
    return $urandom;
  endfunction

  initial begin
    result_bus.ready = 1'b0;
    wait (rst_n);
    forever begin
      int n;
      n = gap_len();
      if (n > 0) begin
        result_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (!(pending_count == 0 && walk_phase == PH_IDLE)) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] data);
    @(posedge clk);
    repeat (gap_len()) @(posedge clk);
    item_bus.opcode     <= op;
    item_bus.pixel_data <= data;
    item_bus.valid      <= 1'b1;
    do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
    item_bus.valid <= 1'b0;
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [1:0] proper_op();
    case (walk_phase)
      PH_SRC:  return OP_SRC_PIX;
      PH_DST:  return OP_DST_PIX;
      default: return OP_START;
    endcase
  endfunction

  task automatic program_regs(logic [25:0] vals [7]);
    wait_idle();
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= 3'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_batch(int n, bit directed, bit drain);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      if (!directed && $urandom_range(0, 99) < 10) op = 2'($urandom_range(0, 3));
      else op = proper_op();
      send_item(op, make_pixel(directed, i));
      if (drain) wait_drained();
    end
    for (int i = 0; walk_phase != PH_IDLE; i++) send_item(proper_op(), make_pixel(0, i));
  endtask

  task automatic random_setup(int mode);
    logic [25:0] v [7];
    int fw, fh;
    case (mode)
      0: begin
        v[REG_IMG_SIZE] = pack_size($urandom_range(1, 16), $urandom_range(1, 16));
        v[REG_SRC_ORG]  = pack_org(int'($urandom_range(0, 16)) - 4,
                                   int'($urandom_range(0, 16)) - 4);
        v[REG_SRC_EXT]  = pack_size($urandom_range(0, 10), $urandom_range(0, 10));
        v[REG_DST_ORG]  = pack_org(int'($urandom_range(0, 14)) - 4,
                                   int'($urandom_range(0, 14)) - 4);
        v[REG_DST_EXT]  = pack_size($urandom_range(0, 9), $urandom_range(0, 9));
        v[REG_FB_SIZE]  = pack_size($urandom_range(1, 12), $urandom_range(1, 12));
      end
      1: begin
        v[REG_IMG_SIZE] = 26'($urandom);
        v[REG_SRC_ORG]  = 26'($urandom);
        v[REG_SRC_EXT]  = 26'($urandom);
        v[REG_DST_ORG]  = ($urandom_range(0, 1) == 0) ? 26'($urandom) : 26'd0;
        v[REG_DST_EXT]  = 26'($urandom);
        v[REG_FB_SIZE]  = {2'($urandom), pack_size($urandom_range(0, 6), $urandom_range(0, 6))};
      end
      default: begin
        fw = $urandom_range(0, 3);
        fh = $urandom_range(0, 3);
        v[REG_IMG_SIZE] = $urandom_range(0, 1) ? pack_size(4095, 4095) : pack_size(1, 1);
        case ($urandom_range(0, 2))
          0: v[REG_SRC_ORG] = pack_org(-4096, -4096);
          1: v[REG_SRC_ORG] = pack_org(4095, 4095);
          default: v[REG_SRC_ORG] = pack_org(0, 0);
        endcase
        v[REG_SRC_EXT] = $urandom_range(0, 1) ? pack_size(4095, 4095) : pack_size(1, 1);
        v[REG_DST_ORG] = $urandom_range(0, 1) ? pack_org(-1, -1) : pack_org(0, 0);
        v[REG_DST_EXT] = $urandom_range(0, 1) ? pack_size(4095, 4095) : pack_size(1, 1);
        v[REG_FB_SIZE] = pack_size(fw, fh);
      end
    endcase
    v[REG_BLEND] = 26'($urandom);
    program_regs(v);
  endtask

  initial begin
    logic [25:0] v [7];
    item_bus.valid      = 1'b0;
    item_bus.opcode     = OP_NONE;
    item_bus.pixel_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_NONE, 32'hFFFF_FFFF);
    send_item(OP_SRC_PIX, 32'hFFFF_FFFF);
    send_item(OP_DST_PIX, 32'h0000_0000);
    send_item(OP_START, 32'h0000_0000);

    v[REG_IMG_SIZE] = pack_size(4, 4);
    v[REG_SRC_ORG]  = pack_org(-1, -1);
    v[REG_SRC_EXT]  = pack_size(3, 3);
    v[REG_DST_ORG]  = pack_org(-1, 0);
    v[REG_DST_EXT]  = pack_size(4, 2);
    v[REG_FB_SIZE]  = pack_size(3, 3);
    v[REG_BLEND]    = 26'd1;
    program_regs(v);
    run_batch(10, 1, 0);
    v[REG_BLEND] = 26'd0;
    program_regs(v);
    run_batch(4, 1, 0);

    v[REG_IMG_SIZE] = pack_size(4095, 4095);
    v[REG_SRC_ORG]  = pack_org(4094, 4094);
    v[REG_SRC_EXT]  = pack_size(4095, 4095);
    v[REG_DST_ORG]  = pack_org(0, 0);
    v[REG_DST_EXT]  = pack_size(4095, 4095);
    v[REG_FB_SIZE]  = pack_size(2, 2);
    program_regs(v);
    run_batch(5, 1, 0);

    v[REG_IMG_SIZE] = pack_size(3, 3);
    v[REG_SRC_ORG]  = pack_org(0, 0);
    v[REG_SRC_EXT]  = pack_size(3, 3);
    v[REG_DST_EXT]  = pack_size(2, 2);
    v[REG_FB_SIZE]  = pack_size(4095, 4095);
    v[REG_DST_ORG]  = pack_org(4093, 4093);
    program_regs(v);
    run_batch(4, 1, 0);

    random_setup(0);
    run_batch(40, 0, 1);
    while (items_sent < 2100) begin
      random_setup($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2));
      run_batch($urandom_range(20, 80), 0, 0);
    end

    for (int i = 0; pending_count != 0; i++) begin
      if (i > 20000) begin
        stuck = 1;
        break;
      end
      @(negedge clk);
    end
    repeat (100) @(negedge clk);
    if (fail_count == 0 && !stuck) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
